// ===== rtl/vsa_pkg.sv =====
package vsa_pkg;

  // Fixed field widths of the item ports
  localparam int FUNC_W     = 2;
  localparam int SOUND_ID_W = 16;
  localparam int DONE_W     = 5;
  localparam int INDEX_W    = 5;
  localparam int KIND_W     = 2;
  localparam int EV_TAG_W   = 16;

  // Function codes of an input item
  localparam logic [FUNC_W-1:0] FUNC_PLAY   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

  // Grant kinds of a result item
  localparam logic [KIND_W-1:0] KIND_HIT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVICT = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch item, clear scan trackers, rewind slot counter
    logic scan;    // issue table read for current slot, advance counter
    logic commit;  // apply item, load output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // slot counter at last slot
    logic out_free;   // output register empty or being taken
  } dp_status_t;

endpackage

// ===== rtl/sound_voice_slot_allocator_top.sv =====
// Voice slot allocator with least-recently-used eviction.
//
// Input channel (in_valid_i / in_ready_o) carries one item: func_i selects
// a play request (sound_id_i is the tag), a voice-finished event (done_slot_i)
// or a one second tick. Output channel (out_valid_o / out_ready_i) returns
// exactly one result item per input item: slot_found_o, slot_index_o,
// grant_kind_o (hit / empty / evict) and evicted_tag_o.
//
// Sequencing: a play request walks the slot table one slot per cycle through
// the tag and last-used memories (one read port each), then drains the last
// read and commits its result to the output register. Finish and tick items
// skip the walk and go straight to the commit. The block takes a new item
// only after it has committed the result of the previous one.
//
// Reset clears all slot valid/active bits, the seconds counter and the output
// valid flag; tag and time memories are not cleared, invalid slots ignore them.
//
// A stalled receiver only holds the output register. The block still accepts
// and works on the next item, and waits with its commit until the output
// register is free, so no result is lost or overwritten.
module sound_voice_slot_allocator_top #(
  parameter int NUM_SLOTS = 32,
  parameter int TAG_BITS  = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [vsa_pkg::FUNC_W-1:0]     func_i,
  input  logic [vsa_pkg::SOUND_ID_W-1:0] sound_id_i,
  input  logic [vsa_pkg::DONE_W-1:0]     done_slot_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           slot_found_o,
  output logic [vsa_pkg::INDEX_W-1:0]    slot_index_o,
  output logic [vsa_pkg::KIND_W-1:0]     grant_kind_o,
  output logic [vsa_pkg::EV_TAG_W-1:0]   evicted_tag_o
);

  vsa_pkg::ctrl_cmd_t  cmd;
  vsa_pkg::dp_status_t status;

  // sequencer: idle / scan / drain of last read / commit
  vsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // slot table, scan trackers, seconds counter and output register
  vsa_datapath #(
    .NUM_SLOTS (NUM_SLOTS),
    .TAG_BITS  (TAG_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .func_i        (func_i),
    .sound_id_i    (sound_id_i),
    .done_slot_i   (done_slot_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .slot_found_o  (slot_found_o),
    .slot_index_o  (slot_index_o),
    .grant_kind_o  (grant_kind_o),
    .evicted_tag_o (evicted_tag_o)
  );

endmodule

// ===== rtl/vsa_ram.sv =====
module vsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vsa_ctrl.sv =====
module vsa_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [vsa_pkg::FUNC_W-1:0]    func_i,
  input  vsa_pkg::dp_status_t           status_i,
  output vsa_pkg::ctrl_cmd_t            cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = (func_i == vsa_pkg::FUNC_PLAY) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last slot read data is evaluated here
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/vsa_datapath.sv =====
module vsa_datapath #(
  parameter int NUM_SLOTS = 32,
  parameter int TAG_BITS  = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [vsa_pkg::FUNC_W-1:0]       func_i,
  input  logic [vsa_pkg::SOUND_ID_W-1:0]   sound_id_i,
  input  logic [vsa_pkg::DONE_W-1:0]       done_slot_i,
  input  vsa_pkg::ctrl_cmd_t               cmd_i,
  output vsa_pkg::dp_status_t              status_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             slot_found_o,
  output logic [vsa_pkg::INDEX_W-1:0]      slot_index_o,
  output logic [vsa_pkg::KIND_W-1:0]       grant_kind_o,
  output logic [vsa_pkg::EV_TAG_W-1:0]     evicted_tag_o
);

  localparam int IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int INDEX_W  = vsa_pkg::INDEX_W;
  localparam int EV_TAG_W = vsa_pkg::EV_TAG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // latched item
  logic [vsa_pkg::FUNC_W-1:0] func_q;
  logic [TAG_BITS-1:0]        tag_q;
  logic [vsa_pkg::DONE_W-1:0] done_q;

  // slot state held in flops
  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic [NUM_SLOTS-1:0] active_q, active_d;
  logic [TIME_BITS-1:0] now_q, now_d;

  // scan
  logic [IDX_W-1:0] cnt_q;
  logic             eval_q;
  logic [IDX_W-1:0] eval_idx_q;

  // scan trackers
  logic                 hit_q, hit_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
  logic                 empty_q, empty_d;
  logic [IDX_W-1:0]     empty_idx_q, empty_idx_d;
  logic                 vic_q, vic_d;
  logic [IDX_W-1:0]     vic_idx_q, vic_idx_d;
  logic [TIME_BITS-1:0] oldest_q, oldest_d;
  logic [TAG_BITS-1:0]  vic_tag_q, vic_tag_d;

  // table memories
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [TAG_BITS-1:0]  tag_rdata;
  logic [TIME_BITS-1:0] time_rdata;
  logic [TIME_BITS-1:0] age;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic                  found_q, found_d;
  logic [INDEX_W-1:0]    index_q, index_d;
  logic [vsa_pkg::KIND_W-1:0] kind_q, kind_d;
  logic [EV_TAG_W-1:0]   ev_tag_q, ev_tag_d;

  logic [IDX_W-1:0] done_idx;

  vsa_ram #(.WIDTH(TAG_BITS), .DEPTH(NUM_SLOTS)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (tag_q),
    .raddr_i (cnt_q),
    .rdata_o (tag_rdata)
  );

  vsa_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_SLOTS)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (now_q),
    .raddr_i (cnt_q),
    .rdata_o (time_rdata)
  );

  assign age      = now_q - time_rdata;
  assign done_idx = IDX_W'(done_q);

  assign status_o.scan_last = (cnt_q == LAST_IDX);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // slot evaluation, one slot a cycle
  always_comb begin
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    empty_d     = empty_q;
    empty_idx_d = empty_idx_q;
    vic_d       = vic_q;
    vic_idx_d   = vic_idx_q;
    oldest_d    = oldest_q;
    vic_tag_d   = vic_tag_q;
    if (cmd_i.start) begin
      hit_d    = 1'b0;
      empty_d  = 1'b0;
      vic_d    = 1'b0;
      oldest_d = '0;
    end else if (eval_q) begin
      if (valid_q[eval_idx_q] && !active_q[eval_idx_q] && (tag_rdata == tag_q)) begin
        if (!hit_q) begin
          hit_d     = 1'b1;
          hit_idx_d = eval_idx_q;
        end
      end else if (!valid_q[eval_idx_q]) begin
        if (!empty_q) begin
          empty_d     = 1'b1;
          empty_idx_d = eval_idx_q;
        end
      end else if (!active_q[eval_idx_q]) begin
        if (age > oldest_q) begin
          vic_d     = 1'b1;
          vic_idx_d = eval_idx_q;
          oldest_d  = age;
          vic_tag_d = tag_rdata;
        end
      end
    end
  end

  // commit of the item
  always_comb begin
    valid_d     = valid_q;
    active_d    = active_q;
    now_d       = now_q;
    we          = 1'b0;
    waddr       = hit_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    index_d     = index_q;
    kind_d      = kind_q;
    ev_tag_d    = ev_tag_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
      found_d     = 1'b0;
      index_d     = '0;
      kind_d      = vsa_pkg::KIND_HIT;
      ev_tag_d    = '0;
      case (func_q)
        vsa_pkg::FUNC_PLAY: begin
          if (hit_q) begin
            we      = 1'b1;
            waddr   = hit_idx_q;
            kind_d  = vsa_pkg::KIND_HIT;
          end else if (empty_q) begin
            we      = 1'b1;
            waddr   = empty_idx_q;
            kind_d  = vsa_pkg::KIND_EMPTY;
          end else if (vic_q) begin
            we       = 1'b1;
            waddr    = vic_idx_q;
            kind_d   = vsa_pkg::KIND_EVICT;
            ev_tag_d = EV_TAG_W'(vic_tag_q);
          end
          if (we) begin
            found_d         = 1'b1;
            index_d         = INDEX_W'(waddr);
            valid_d[waddr]  = 1'b1;
            active_d[waddr] = 1'b1;
          end
        end
        vsa_pkg::FUNC_FINISH: begin
          if (32'(done_q) < NUM_SLOTS) begin
            active_d[done_idx] = 1'b0;
          end
        end
        vsa_pkg::FUNC_TICK: begin
          now_d = now_q + TIME_BITS'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      active_q    <= '0;
      now_q       <= '0;
      cnt_q       <= '0;
      eval_q      <= 1'b0;
      hit_q       <= 1'b0;
      empty_q     <= 1'b0;
      vic_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      active_q    <= active_d;
      now_q       <= now_d;
      eval_q      <= cmd_i.scan;
      hit_q       <= hit_d;
      empty_q     <= empty_d;
      vic_q       <= vic_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (cmd_i.scan) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q <= func_i;
      tag_q  <= TAG_BITS'(sound_id_i);
      done_q <= done_slot_i;
    end
    eval_idx_q  <= cnt_q;
    hit_idx_q   <= hit_idx_d;
    empty_idx_q <= empty_idx_d;
    vic_idx_q   <= vic_idx_d;
    oldest_q    <= oldest_d;
    vic_tag_q   <= vic_tag_d;
    found_q     <= found_d;
    index_q     <= index_d;
    kind_q      <= kind_d;
    ev_tag_q    <= ev_tag_d;
  end

  assign out_valid_o   = out_valid_q;
  assign slot_found_o  = found_q;
  assign slot_index_o  = index_q;
  assign grant_kind_o  = kind_q;
  assign evicted_tag_o = ev_tag_q;

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS = 32;
  localparam int TAG_BITS  = 16;
  localparam int TIME_BITS = 32;

  // Unused function code: the block answers with an all-zero result, no state change.
  localparam logic [vsa_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;

  localparam int NUM_RANDOM_ITEMS = 1050;
  localparam int TAG_POOL_SIZE    = 48;

  // One result item as seen on the output ports.
  typedef struct packed {
    logic                         found;
    logic [vsa_pkg::INDEX_W-1:0]  index;
    logic [vsa_pkg::KIND_W-1:0]   kind;
    logic [vsa_pkg::EV_TAG_W-1:0] ev_tag;
  } grant_t;

  // Tracks the slot table and keeps the grants still owed by the block.
  class voice_grant_checker;
    bit                   valid_q  [NUM_SLOTS];
    bit                   active_q [NUM_SLOTS];
    logic [TAG_BITS-1:0]  tag_q    [NUM_SLOTS];
    logic [TIME_BITS-1:0] used_at_q[NUM_SLOTS];
    logic [TIME_BITS-1:0] now_sec;
    grant_t               pending_grants[$];
    int                   errors;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        valid_q[i]   = 1'b0;
        active_q[i]  = 1'b0;
        tag_q[i]     = '0;
        used_at_q[i] = '0;
      end
      now_sec = '0;
      errors  = 0;
    endfunction

    function int pending();
      return pending_grants.size();
    endfunction

    // Apply one accepted item to the table and queue the grant it must produce.
    function void note_item(logic [vsa_pkg::FUNC_W-1:0] func,
                            logic [vsa_pkg::SOUND_ID_W-1:0] sid,
                            logic [vsa_pkg::DONE_W-1:0] done);
      grant_t               res;
      int                   hit;
      int                   empty;
      int                   victim;
      int                   pick;
      logic [TIME_BITS-1:0] age;
      logic [TIME_BITS-1:0] oldest;
      res    = '0;
      hit    = -1;
      empty  = -1;
      victim = -1;
      pick   = -1;
      oldest = '0;
      case (func)
        vsa_pkg::FUNC_PLAY: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (valid_q[i] && !active_q[i] && tag_q[i] == sid[TAG_BITS-1:0]) begin
              if (hit < 0) hit = i;
            end else if (!valid_q[i]) begin
              if (empty < 0) empty = i;
            end else if (!active_q[i]) begin
              age = now_sec - used_at_q[i];
              // strict compare: ties go to the lowest index, age zero never evicts
              if (age > oldest) begin
                oldest = age;
                victim = i;
              end
            end
          end
          if (hit >= 0) begin
            pick     = hit;
            res.kind = vsa_pkg::KIND_HIT;
          end else if (empty >= 0) begin
            pick     = empty;
            res.kind = vsa_pkg::KIND_EMPTY;
          end else if (victim >= 0) begin
            pick       = victim;
            res.kind   = vsa_pkg::KIND_EVICT;
            res.ev_tag = tag_q[victim][vsa_pkg::EV_TAG_W-1:0];
          end
          if (pick >= 0) begin
            res.found       = 1'b1;
            res.index       = pick[vsa_pkg::INDEX_W-1:0];
            valid_q[pick]   = 1'b1;
            active_q[pick]  = 1'b1;
            tag_q[pick]     = sid[TAG_BITS-1:0];
            used_at_q[pick] = now_sec;
          end
        end
        vsa_pkg::FUNC_FINISH: begin
          if (int'(done) < NUM_SLOTS) active_q[done] = 1'b0;
        end
        vsa_pkg::FUNC_TICK: now_sec = now_sec + TIME_BITS'(1);
        default: ;
      endcase
      pending_grants.push_back(res);
    endfunction

    function void check_grant(grant_t got);
      grant_t exp_g;
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result found=%0d index=%0d kind=%0d ev_tag=%h",
                 $time, got.found, got.index, got.kind, got.ev_tag);
        errors++;
        return;
      end
      exp_g = pending_grants.pop_front();
      if (got.found !== exp_g.found) begin
        $display("%0t: slot_found expected %0d actual %0d", $time, exp_g.found, got.found);
        errors++;
      end
      if (got.index !== exp_g.index) begin
        $display("%0t: slot_index expected %0d actual %0d", $time, exp_g.index, got.index);
        errors++;
      end
      if (got.kind !== exp_g.kind) begin
        $display("%0t: grant_kind expected %0d actual %0d", $time, exp_g.kind, got.kind);
        errors++;
      end
      if (got.ev_tag !== exp_g.ev_tag) begin
        $display("%0t: evicted_tag expected %h actual %h", $time, exp_g.ev_tag, got.ev_tag);
        errors++;
      end
    endfunction
  endclass

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  // Block inputs, all known from time zero
  logic                           in_valid_i  = 1'b0;
  logic [vsa_pkg::FUNC_W-1:0]     func_i      = FUNC_NOP;
  logic [vsa_pkg::SOUND_ID_W-1:0] sound_id_i  = '0;
  logic [vsa_pkg::DONE_W-1:0]     done_slot_i = '0;
  logic                           out_ready_i = 1'b0;

  logic                           in_ready_o;
  logic                           out_valid_o;
  logic                           slot_found_o;
  logic [vsa_pkg::INDEX_W-1:0]    slot_index_o;
  logic [vsa_pkg::KIND_W-1:0]     grant_kind_o;
  logic [vsa_pkg::EV_TAG_W-1:0]   evicted_tag_o;

  sound_voice_slot_allocator_top #(
    .NUM_SLOTS(NUM_SLOTS),
    .TAG_BITS (TAG_BITS),
    .TIME_BITS(TIME_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .sound_id_i   (sound_id_i),
    .done_slot_i  (done_slot_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .slot_found_o (slot_found_o),
    .slot_index_o (slot_index_o),
    .grant_kind_o (grant_kind_o),
    .evicted_tag_o(evicted_tag_o)
  );

  voice_grant_checker grants = new();

  // Both handshakes are sampled at the same edge the block sees them, so the
  // values read here are the pre-edge ones regardless of process order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        grants.note_item(func_i, sound_id_i, done_slot_i);
      if (out_valid_o && out_ready_i)
        grants.check_grant({slot_found_o, slot_index_o, grant_kind_o, evicted_tag_o});
    end
  end

  // Receiver backpressure: runs of ready, short stalls, a toggling ready,
  // and long stretches with no stall at all.
  int rx_mode;
  int rx_left;
  always @(posedge clk_i) begin
    if (rx_left <= 0) begin
      rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       rx_left = $urandom_range(60, 300);
        1:       rx_left = $urandom_range(1, 6);
        2:       rx_left = $urandom_range(8, 40);
        default: rx_left = $urandom_range(1, 12);
      endcase
    end
    rx_left--;
    case (rx_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'b0;
      2:       out_ready_i <= ~out_ready_i;
      default: out_ready_i <= 1'b1;
    endcase
  end

  // Small tag set so that repeated plays actually hit loaded slots.
  logic [vsa_pkg::SOUND_ID_W-1:0] tag_pool[TAG_POOL_SIZE];

  // Present one item and hold it until the block takes it. Returns at the
  // accepting edge with valid still high, so a following item simply
  // overwrites the payload in the same step.
  task automatic send_item(logic [vsa_pkg::FUNC_W-1:0] func,
                           logic [vsa_pkg::SOUND_ID_W-1:0] sid,
                           logic [vsa_pkg::DONE_W-1:0] done);
    in_valid_i  <= 1'b1;
    func_i      <= func;
    sound_id_i  <= sid;
    done_slot_i <= done;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Mostly plays from the tag pool, with finishes freeing slots and ticks
  // aging them; this keeps the table full so hits, evictions, equal-age
  // ties and the no-slot case all keep recurring.
  task automatic send_random_item();
    int                             pick;
    logic [vsa_pkg::SOUND_ID_W-1:0] sid;
    logic [vsa_pkg::DONE_W-1:0]     done;
    pick = $urandom_range(0, 99);
    sid  = vsa_pkg::SOUND_ID_W'($urandom());
    done = vsa_pkg::DONE_W'($urandom());
    if (pick < 50) begin
      if ($urandom_range(0, 6) != 0) sid = tag_pool[$urandom_range(0, TAG_POOL_SIZE - 1)];
      send_item(vsa_pkg::FUNC_PLAY, sid, done);
    end else if (pick < 78) begin
      send_item(vsa_pkg::FUNC_FINISH, sid, done);
    end else if (pick < 95) begin
      send_item(vsa_pkg::FUNC_TICK, sid, done);
    end else begin
      send_item(FUNC_NOP, sid, done);
    end
  endtask

  initial begin
    int sent;
    int burst;

    for (int i = 0; i < TAG_POOL_SIZE; i++) tag_pool[i] = vsa_pkg::SOUND_ID_W'($urandom());
    tag_pool[0] = '0;
    tag_pool[1] = '1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening
    send_item(FUNC_NOP, 16'hFFFF, 5'd31);             // unused code: zero result
    send_item(vsa_pkg::FUNC_PLAY, 16'h0000, 5'd0);    // tag zero on empty table: no hit
    send_item(vsa_pkg::FUNC_PLAY, 16'hFFFF, 5'd31);   // next empty slot
    send_item(vsa_pkg::FUNC_PLAY, 16'hFFFF, 5'd0);    // same tag but slot busy: empty slot
    send_item(vsa_pkg::FUNC_FINISH, 16'h0000, 5'd0);
    send_item(vsa_pkg::FUNC_PLAY, 16'h0000, 5'd0);    // idle slot with same tag: hit
    send_item(vsa_pkg::FUNC_FINISH, 16'hFFFF, 5'd31); // slot never used: no change
    send_item(vsa_pkg::FUNC_FINISH, 16'h0000, 5'd1);
    send_item(vsa_pkg::FUNC_FINISH, 16'h0000, 5'd2);
    send_item(vsa_pkg::FUNC_PLAY, 16'hFFFF, 5'd0);    // two idle copies: lowest one hits
    send_item(vsa_pkg::FUNC_TICK, 16'h0000, 5'd0);
    send_item(vsa_pkg::FUNC_TICK, 16'hFFFF, 5'd31);
    send_item(vsa_pkg::FUNC_PLAY, 16'h8001, 5'd0);
    send_item(FUNC_NOP, 16'h0000, 5'd0);
    send_item(vsa_pkg::FUNC_FINISH, 16'h0000, 5'd0);
    send_item(vsa_pkg::FUNC_FINISH, 16'h0000, 5'd0);  // second finish on the same slot
    send_item(vsa_pkg::FUNC_PLAY, 16'h7FFE, 5'd0);
    idle_gap(5);

    // Random part in bursts; every other stretch of 200 items runs without gaps.
    sent = 0;
    while (sent < NUM_RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst; k++) send_random_item();
      sent += burst;
      if ((sent / 200) % 2 == 0 && $urandom_range(0, 3) != 0)
        idle_gap($urandom_range(1, 10));
    end
    idle_gap(1);

    while (grants.pending() != 0) @(posedge clk_i);
    // catch any stray result beyond the last expected one
    repeat (NUM_SLOTS + 8) @(posedge clk_i);

    if (grants.errors == 0 && grants.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
